@@ rtl/core/ccbus_pkg.sv @@
// Types and constants for the console CPU bus with sprite DMA.
// Shared by the top level and its bench; no dependencies.
package ccbus_pkg;

	localparam int RAM_DEPTH = 2048;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [2:0] ROUTE_NONE = 3'd0;
	localparam logic [2:0] ROUTE_RAM  = 3'd1;
	localparam logic [2:0] ROUTE_PPU  = 3'd2;
	localparam logic [2:0] ROUTE_PAD  = 3'd3;
	localparam logic [2:0] ROUTE_CART = 3'd4;
	localparam logic [2:0] ROUTE_DMA  = 3'd5;

	localparam logic [15:0] ADDR_RAM_END   = 16'h1FFF;
	localparam logic [15:0] ADDR_PPU_END   = 16'h3FFF;
	localparam logic [15:0] ADDR_DMA_PAGE  = 16'h4014;
	localparam logic [15:0] ADDR_PAD0      = 16'h4016;
	localparam logic [15:0] ADDR_PAD1      = 16'h4017;
	localparam logic [15:0] ADDR_CART_BASE = 16'h8000;

	localparam logic [2:0] PHASE_FETCH = 3'd0;
	localparam logic [2:0] PHASE_STORE = 3'd3;
	localparam logic [2:0] PHASE_LAST  = 3'd5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  pad0_buttons;
		logic [7:0]  pad1_buttons;
		logic [7:0]  ext_read_data;
		logic        ppu_nmi;
	} bus_req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [2:0]  route;
		logic [15:0] fwd_addr;
		logic        fwd_write;
		logic [7:0]  fwd_data;
		logic        cpu_step;
		logic        oam_write_valid;
		logic [7:0]  oam_index;
		logic [7:0]  oam_data;
		logic        cpu_nmi;
	} bus_rsp_t;

endpackage

@@ rtl/core/console_cpu_bus_with_oam_dma_top.sv @@
// Console CPU bus decode, pad ports and sprite DMA around a synchronous work RAM.
// Depends on ccbus_pkg.
//
// channel  | signals                       | payload
// ---------+-------------------------------+------------------------------
// request  | req_valid, req_ready, req     | ccbus_pkg::bus_req_t
// response | rsp_valid, rsp_ready, rsp     | ccbus_pkg::bus_rsp_t
//
// One beat per cycle while rsp_ready keeps up and no clearing pass runs; each
// request passes the RAM read stage, then the output register. The work RAM
// read port sets the latency. After reset a clearing pass zeroes all RAM_DEPTH
// (2048) words of the RAM, with req_ready low. A stalled response holds in the
// output register while one more request is taken into the RAM read stage.
module console_cpu_bus_with_oam_dma_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ccbus_pkg::bus_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ccbus_pkg::bus_rsp_t rsp
);

	logic [7:0] ram_q [ccbus_pkg::RAM_DEPTH];
	logic [7:0] ram_rd_q;
	logic       ram_we;
	logic       ram_re;
	logic [ccbus_pkg::RAM_AW-1:0] ram_wa;
	logic [ccbus_pkg::RAM_AW-1:0] ram_ra;
	logic [7:0] ram_wd;

	logic [ccbus_pkg::RAM_AW-1:0] clr_idx_q;
	logic       clr_busy_q;

	logic [7:0] pad_shift_q [2];
	logic [2:0] tick_phase_q;
	logic [7:0] dma_page_q;
	logic [7:0] dma_index_q;
	logic [7:0] dma_byte_q;
	logic       dma_wait_q;
	logic       dma_active_q;

	logic [7:0] pad_shift_d [2];
	logic [2:0] tick_phase_d;
	logic [7:0] dma_page_d;
	logic [7:0] dma_index_d;
	logic       dma_wait_d;
	logic       dma_active_d;

	logic                valid_s1;
	ccbus_pkg::bus_rsp_t res_s1;
	logic                ram_sel_s1;
	logic                fetch_s1;

	ccbus_pkg::bus_rsp_t res_d;
	logic                ram_sel_d;
	logic                fetch_d;
	ccbus_pkg::bus_rsp_t res_fin;

	logic        accept;
	logic        adv_s1;
	logic        do_rd;
	logic [15:0] rd_a;
	logic [7:0]  index_inc;

	assign adv_s1    = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign accept    = req_valid && req_ready;
	assign index_inc = dma_index_q + 8'd1;

	always_comb begin
		res_d        = '0;
		ram_sel_d    = 1'b0;
		fetch_d      = 1'b0;
		do_rd        = 1'b0;
		rd_a         = req.address;
		ram_re       = 1'b0;
		ram_ra       = rd_a[ccbus_pkg::RAM_AW-1:0];
		ram_we       = 1'b0;
		ram_wa       = req.address[ccbus_pkg::RAM_AW-1:0];
		ram_wd       = req.write_data;
		pad_shift_d  = pad_shift_q;
		tick_phase_d = tick_phase_q;
		dma_page_d   = dma_page_q;
		dma_index_d  = dma_index_q;
		dma_wait_d   = dma_wait_q;
		dma_active_d = dma_active_q;

		if (accept) begin
			case (req.operation)
				ccbus_pkg::OP_READ: begin
					do_rd = 1'b1;
				end
				ccbus_pkg::OP_WRITE: begin
					if (req.address <= ccbus_pkg::ADDR_RAM_END) begin
						ram_we       = 1'b1;
						res_d.route  = ccbus_pkg::ROUTE_RAM;
					end else if (req.address <= ccbus_pkg::ADDR_PPU_END) begin
						res_d.route     = ccbus_pkg::ROUTE_PPU;
						res_d.fwd_addr  = {13'd0, req.address[2:0]};
						res_d.fwd_write = 1'b1;
						res_d.fwd_data  = req.write_data;
					end else if (req.address == ccbus_pkg::ADDR_DMA_PAGE) begin
						dma_page_d   = req.write_data;
						dma_index_d  = 8'd0;
						dma_active_d = 1'b1;
						res_d.route  = ccbus_pkg::ROUTE_DMA;
					end else if (req.address == ccbus_pkg::ADDR_PAD0) begin
						pad_shift_d[0] = req.pad0_buttons;
						res_d.route    = ccbus_pkg::ROUTE_PAD;
					end else if (req.address == ccbus_pkg::ADDR_PAD1) begin
						pad_shift_d[1] = req.pad1_buttons;
						res_d.route    = ccbus_pkg::ROUTE_PAD;
					end else if (req.address >= ccbus_pkg::ADDR_CART_BASE) begin
						res_d.route     = ccbus_pkg::ROUTE_CART;
						res_d.fwd_addr  = req.address;
						res_d.fwd_write = 1'b1;
						res_d.fwd_data  = req.write_data;
					end
				end
				ccbus_pkg::OP_TICK: begin
					if (tick_phase_q == ccbus_pkg::PHASE_FETCH ||
					    tick_phase_q == ccbus_pkg::PHASE_STORE) begin
						if (dma_active_q) begin
							if (dma_wait_q) begin
								if (tick_phase_q == ccbus_pkg::PHASE_STORE)
									dma_wait_d = 1'b0;
							end else if (tick_phase_q == ccbus_pkg::PHASE_FETCH) begin
								do_rd   = 1'b1;
								fetch_d = 1'b1;
								rd_a    = {dma_page_q, dma_index_q};
							end else begin
								res_d.oam_write_valid = 1'b1;
								res_d.oam_index       = dma_index_q;
								res_d.oam_data        = dma_byte_q;
								dma_index_d           = index_inc;
								if (index_inc == 8'd0) begin
									dma_active_d = 1'b0;
									dma_wait_d   = 1'b1;
								end
							end
						end else begin
							res_d.cpu_step = 1'b1;
						end
					end
					res_d.cpu_nmi = req.ppu_nmi;
					tick_phase_d  = (tick_phase_q == ccbus_pkg::PHASE_LAST) ?
						3'd0 : tick_phase_q + 3'd1;
				end
				default: ;
			endcase

			if (do_rd) begin
				ram_ra = rd_a[ccbus_pkg::RAM_AW-1:0];
				if (rd_a <= ccbus_pkg::ADDR_RAM_END) begin
					ram_re      = 1'b1;
					ram_sel_d   = 1'b1;
					res_d.route = ccbus_pkg::ROUTE_RAM;
				end else if (rd_a <= ccbus_pkg::ADDR_PPU_END) begin
					res_d.read_data = req.ext_read_data;
					res_d.route     = ccbus_pkg::ROUTE_PPU;
					res_d.fwd_addr  = {13'd0, rd_a[2:0]};
				end else if (rd_a == ccbus_pkg::ADDR_PAD0 || rd_a == ccbus_pkg::ADDR_PAD1) begin
					res_d.read_data         = {7'd0, pad_shift_q[rd_a[0]][7]};
					pad_shift_d[rd_a[0]]    = {pad_shift_q[rd_a[0]][6:0], 1'b0};
					res_d.route             = ccbus_pkg::ROUTE_PAD;
				end else if (rd_a >= ccbus_pkg::ADDR_CART_BASE) begin
					res_d.read_data = req.ext_read_data;
					res_d.route     = ccbus_pkg::ROUTE_CART;
					res_d.fwd_addr  = rd_a;
				end else if (rd_a == ccbus_pkg::ADDR_DMA_PAGE) begin
					res_d.route = ccbus_pkg::ROUTE_DMA;
				end
			end
		end

		// clearing pass owns the write port
		if (clr_busy_q) begin
			ram_we = 1'b1;
			ram_wa = clr_idx_q;
			ram_wd = 8'd0;
		end
	end

	always_comb begin
		res_fin = res_s1;
		if (ram_sel_s1)
			res_fin.read_data = ram_rd_q;
	end

	always_ff @(posedge clk) begin
		if (ram_we)
			ram_q[ram_wa] <= ram_wd;
		if (ram_re)
			ram_rd_q <= ram_q[ram_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + ccbus_pkg::RAM_AW'(1);
			if (clr_idx_q == ccbus_pkg::RAM_AW'(ccbus_pkg::RAM_DEPTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_shift_q[0] <= 8'd0;
			pad_shift_q[1] <= 8'd0;
			tick_phase_q   <= 3'd0;
			dma_page_q     <= 8'd0;
			dma_index_q    <= 8'd0;
			dma_wait_q     <= 1'b1;
			dma_active_q   <= 1'b0;
		end else begin
			pad_shift_q  <= pad_shift_d;
			tick_phase_q <= tick_phase_d;
			dma_page_q   <= dma_page_d;
			dma_index_q  <= dma_index_d;
			dma_wait_q   <= dma_wait_d;
			dma_active_q <= dma_active_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dma_byte_q <= 8'd0;
		else if (adv_s1 && fetch_s1)
			dma_byte_q <= res_fin.read_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res_d;
			ram_sel_s1 <= ram_sel_d;
			fetch_s1   <= fetch_d;
		end
		if (adv_s1)
			rsp <= res_fin;
	end

endmodule

@@ sim/console_cpu_bus_with_oam_dma_top_tb.sv @@
// Self-checking bench for console_cpu_bus_with_oam_dma_top: bus decode, pad ports, sprite DMA.
// Holds a cycle-free mirror of the bus and its DMA to predict each response beat.
// Depends on ccbus_pkg and the top level only.
`timescale 1ns / 1ps

module console_cpu_bus_with_oam_dma_top_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	class console_bus_mirror;
		logic [7:0] ram [ccbus_pkg::RAM_DEPTH];
		logic [7:0] pad_latch [2];
		logic [2:0] phase;
		logic [7:0] page;
		logic [7:0] idx;
		logic [7:0] fetched;
		bit         align_wait;
		bit         dma_on;
		ccbus_pkg::bus_rsp_t due_rsp [$];
		int         checked;
		int         mismatches;
		int         oam_bytes;
		int         dma_done;
		int         pad_reads;

		function new();
			foreach (ram[i]) ram[i] = '0;
			pad_latch[0] = '0;
			pad_latch[1] = '0;
			phase = '0;
			page = '0;
			idx = '0;
			fetched = '0;
			align_wait = 1'b1;
			dma_on = 1'b0;
		endfunction

		function logic [7:0] mirror_read(input logic [15:0] a, input logic [7:0] ext,
			inout ccbus_pkg::bus_rsp_t e);
			logic [7:0] d;
			d = '0;
			if (a <= ccbus_pkg::ADDR_RAM_END) begin
				d = ram[a % ccbus_pkg::RAM_DEPTH];
				e.route = ccbus_pkg::ROUTE_RAM;
			end else if (a <= ccbus_pkg::ADDR_PPU_END) begin
				d = ext;
				e.route = ccbus_pkg::ROUTE_PPU;
				e.fwd_addr = {13'd0, a[2:0]};
			end else if (a == ccbus_pkg::ADDR_PAD0 || a == ccbus_pkg::ADDR_PAD1) begin
				d = {7'd0, pad_latch[a[0]][7]};
				pad_latch[a[0]] = pad_latch[a[0]] << 1;
				e.route = ccbus_pkg::ROUTE_PAD;
				pad_reads++;
			end else if (a >= ccbus_pkg::ADDR_CART_BASE) begin
				d = ext;
				e.route = ccbus_pkg::ROUTE_CART;
				e.fwd_addr = a;
			end else if (a == ccbus_pkg::ADDR_DMA_PAGE) begin
				e.route = ccbus_pkg::ROUTE_DMA;
			end
			e.read_data = d;
			return d;
		endfunction

		function void note_request(input ccbus_pkg::bus_req_t r);
			ccbus_pkg::bus_rsp_t e;
			e = '0;
			case (r.operation)
			ccbus_pkg::OP_READ: begin
				void'(mirror_read(r.address, r.ext_read_data, e));
			end
			ccbus_pkg::OP_WRITE: begin
				if (r.address <= ccbus_pkg::ADDR_RAM_END) begin
					ram[r.address % ccbus_pkg::RAM_DEPTH] = r.write_data;
					e.route = ccbus_pkg::ROUTE_RAM;
				end else if (r.address <= ccbus_pkg::ADDR_PPU_END) begin
					e.route = ccbus_pkg::ROUTE_PPU;
					e.fwd_addr = {13'd0, r.address[2:0]};
					e.fwd_write = 1'b1;
					e.fwd_data = r.write_data;
				end else if (r.address == ccbus_pkg::ADDR_DMA_PAGE) begin
					page = r.write_data;
					idx = '0;
					dma_on = 1'b1;
					e.route = ccbus_pkg::ROUTE_DMA;
				end else if (r.address == ccbus_pkg::ADDR_PAD0 ||
					r.address == ccbus_pkg::ADDR_PAD1) begin
					pad_latch[r.address[0]] = r.address[0] ? r.pad1_buttons : r.pad0_buttons;
					e.route = ccbus_pkg::ROUTE_PAD;
				end else if (r.address >= ccbus_pkg::ADDR_CART_BASE) begin
					e.route = ccbus_pkg::ROUTE_CART;
					e.fwd_addr = r.address;
					e.fwd_write = 1'b1;
					e.fwd_data = r.write_data;
				end
			end
			ccbus_pkg::OP_TICK: begin
				if (phase == ccbus_pkg::PHASE_FETCH || phase == ccbus_pkg::PHASE_STORE) begin
					if (!dma_on) begin
						e.cpu_step = 1'b1;
					end else if (align_wait) begin
						if (phase == ccbus_pkg::PHASE_STORE)
							align_wait = 1'b0;
					end else if (phase == ccbus_pkg::PHASE_FETCH) begin
						fetched = mirror_read({page, idx}, r.ext_read_data, e);
					end else begin
						e.oam_write_valid = 1'b1;
						e.oam_index = idx;
						e.oam_data = fetched;
						idx++;
						if (idx == '0) begin
							dma_on = 1'b0;
							align_wait = 1'b1;
							dma_done++;
						end
					end
				end
				e.cpu_nmi = r.ppu_nmi;
				phase = (phase == ccbus_pkg::PHASE_LAST) ? ccbus_pkg::PHASE_FETCH
					: phase + 3'd1;
			end
			default: begin
			end
			endcase
			due_rsp.push_back(e);
		endfunction

		function void check_response(input ccbus_pkg::bus_rsp_t got);
			ccbus_pkg::bus_rsp_t e;
			string diff;
			diff = "";
			if (due_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response beat with nothing due: %h", $realtime, got);
				return;
			end
			e = due_rsp.pop_front();
			checked++;
			if (got.oam_write_valid === 1'b1)
				oam_bytes++;
			if (got.read_data !== e.read_data) diff = {diff, " read_data"};
			if (got.route !== e.route) diff = {diff, " route"};
			if (got.fwd_addr !== e.fwd_addr) diff = {diff, " fwd_addr"};
			if (got.fwd_write !== e.fwd_write) diff = {diff, " fwd_write"};
			if (got.fwd_data !== e.fwd_data) diff = {diff, " fwd_data"};
			if (got.cpu_step !== e.cpu_step) diff = {diff, " cpu_step"};
			if (got.oam_write_valid !== e.oam_write_valid) diff = {diff, " oam_write_valid"};
			if (got.oam_index !== e.oam_index) diff = {diff, " oam_index"};
			if (got.oam_data !== e.oam_data) diff = {diff, " oam_data"};
			if (got.cpu_nmi !== e.cpu_nmi) diff = {diff, " cpu_nmi"};
			if (diff != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: beat %0d differs in%s: expected %h, got %h",
						$realtime, checked, diff, e, got);
			end
		endfunction

		function int pending();
			return due_rsp.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	ccbus_pkg::bus_req_t req;
	logic                rsp_valid;
	logic                rsp_ready;
	ccbus_pkg::bus_rsp_t rsp;

	console_bus_mirror bus;
	int  sent;
	bit  calm;

	console_cpu_bus_with_oam_dma_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic ccbus_pkg::bus_req_t make_req(input logic [1:0] op,
		input logic [15:0] a, input logic [7:0] wd);
		ccbus_pkg::bus_req_t r;
		r.operation = op;
		r.address = a;
		r.write_data = wd;
		r.pad0_buttons = 8'($urandom_range(0, 255));
		r.pad1_buttons = 8'($urandom_range(0, 255));
		r.ext_read_data = 8'($urandom_range(0, 255));
		r.ppu_nmi = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 9))
		0, 1, 2: return 16'($urandom_range(0, ccbus_pkg::ADDR_RAM_END));
		3:       return 16'($urandom_range(ccbus_pkg::ADDR_RAM_END + 1,
			ccbus_pkg::ADDR_PPU_END));
		4:       return $urandom_range(0, 1) ? ccbus_pkg::ADDR_PAD1 : ccbus_pkg::ADDR_PAD0;
		5:       return ccbus_pkg::ADDR_DMA_PAGE;
		6:       return 16'($urandom_range(ccbus_pkg::ADDR_PPU_END + 1,
			ccbus_pkg::ADDR_CART_BASE - 1));
		default: return 16'($urandom_range(ccbus_pkg::ADDR_CART_BASE, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [7:0] pick_page();
		case ($urandom_range(0, 5))
		0, 1:    return 8'($urandom_range(8'h00, 8'h1F));
		2:       return 8'($urandom_range(8'h20, 8'h3F));
		3:       return 8'h40;
		4:       return 8'($urandom_range(8'h41, 8'h7F));
		default: return 8'($urandom_range(8'h80, 8'hFF));
		endcase
	endfunction

	// Entered just after a rising edge; returns just after the edge that took the beat.
	task automatic send(input ccbus_pkg::bus_req_t r);
		int unsigned gap;
		if ($urandom_range(0, 63) == 0)
			calm = !calm;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		bus.note_request(r);
		sent++;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [15:0] a, input logic [7:0] wd);
		send(make_req(op, a, wd));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (bus.pending() != 0);
	endtask

	task automatic run_directed();
		ccbus_pkg::bus_req_t r;
		send_op(ccbus_pkg::OP_WRITE, 16'h0000, 8'hFF);
		send_op(ccbus_pkg::OP_READ, 16'h1800, 8'h00);
		send_op(ccbus_pkg::OP_WRITE, 16'h07FF, 8'h5A);
		send_op(ccbus_pkg::OP_READ, ccbus_pkg::ADDR_RAM_END, 8'h00);
		r = make_req(ccbus_pkg::OP_READ, 16'h2000, 8'h00);
		r.ext_read_data = 8'hA5;
		send(r);
		send_op(ccbus_pkg::OP_WRITE, ccbus_pkg::ADDR_PPU_END, 8'h3C);
		r = make_req(ccbus_pkg::OP_WRITE, ccbus_pkg::ADDR_PAD0, 8'h00);
		r.pad0_buttons = 8'h81;
		r.pad1_buttons = 8'h7E;
		send(r);
		send_op(ccbus_pkg::OP_READ, ccbus_pkg::ADDR_PAD0, 8'h00);
		send_op(ccbus_pkg::OP_READ, ccbus_pkg::ADDR_PAD0, 8'h00);
		r = make_req(ccbus_pkg::OP_WRITE, ccbus_pkg::ADDR_PAD1, 8'h00);
		r.pad1_buttons = 8'h7E;
		send(r);
		send_op(ccbus_pkg::OP_READ, ccbus_pkg::ADDR_PAD1, 8'h00);
		send_op(ccbus_pkg::OP_READ, ccbus_pkg::ADDR_DMA_PAGE, 8'h00);
		send_op(ccbus_pkg::OP_READ, 16'h4000, 8'h00);
		send_op(ccbus_pkg::OP_WRITE, 16'h7FFF, 8'hFF);
		r = make_req(ccbus_pkg::OP_READ, ccbus_pkg::ADDR_CART_BASE, 8'h00);
		r.ext_read_data = 8'hFF;
		send(r);
		send_op(ccbus_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
		r = '1;
		r.operation = OP_UNUSED;
		send(r);
		// start from RAM page 7, run through alignment and one fetch
		send_op(ccbus_pkg::OP_WRITE, ccbus_pkg::ADDR_DMA_PAGE, 8'h07);
		for (int i = 0; i < 8; i++) begin
			r = make_req(ccbus_pkg::OP_TICK, 16'h0000, 8'h00);
			r.ppu_nmi = (i == 0);
			send(r);
		end
		// restart while busy
		send_op(ccbus_pkg::OP_WRITE, ccbus_pkg::ADDR_DMA_PAGE, 8'h80);
	endtask

	task automatic run_mixed(input int until_sent);
		ccbus_pkg::bus_req_t r;
		logic [15:0] a;
		int n;
		while (sent < until_sent) begin
			case ($urandom_range(0, 9))
			0: begin
				a = $urandom_range(0, 1) ? ccbus_pkg::ADDR_PAD1 : ccbus_pkg::ADDR_PAD0;
				send_op(ccbus_pkg::OP_WRITE, a, 8'($urandom_range(0, 255)));
				n = $urandom_range(1, 10);
				repeat (n) send_op(ccbus_pkg::OP_READ, a, 8'($urandom_range(0, 255)));
			end
			1, 2: begin
				a = 16'($urandom_range(0, ccbus_pkg::RAM_DEPTH - 1));
				send_op(ccbus_pkg::OP_WRITE, a | 16'($urandom_range(0, 3) << 11),
					8'($urandom_range(0, 255)));
				send_op(ccbus_pkg::OP_READ, a | 16'($urandom_range(0, 3) << 11),
					8'($urandom_range(0, 255)));
			end
			3: begin
				a = $urandom_range(0, 1)
					? 16'($urandom_range(ccbus_pkg::ADDR_RAM_END + 1, ccbus_pkg::ADDR_PPU_END))
					: 16'($urandom_range(ccbus_pkg::ADDR_CART_BASE, 16'hFFFF));
				send_op($urandom_range(0, 1) ? ccbus_pkg::OP_WRITE : ccbus_pkg::OP_READ, a,
					8'($urandom_range(0, 255)));
			end
			4, 5: begin
				n = $urandom_range(1, 40);
				repeat (n) send_op(ccbus_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)),
					8'($urandom_range(0, 255)));
			end
			6: begin
				send_op(ccbus_pkg::OP_WRITE, ccbus_pkg::ADDR_DMA_PAGE, pick_page());
				n = $urandom_range(10, 60);
				repeat (n) send_op(ccbus_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)),
					8'($urandom_range(0, 255)));
			end
			7: begin
				r = make_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
					8'($urandom_range(0, 255)));
				send(r);
			end
			default: begin
				send_op($urandom_range(0, 1) ? ccbus_pkg::OP_WRITE : ccbus_pkg::OP_READ,
					pick_addr(), 8'($urandom_range(0, 255)));
			end
			endcase
		end
	endtask

	// One whole sprite transfer, with the odd CPU access slipped in between ticks.
	task automatic run_full_dma();
		ccbus_pkg::bus_req_t r;
		send_op(ccbus_pkg::OP_WRITE, ccbus_pkg::ADDR_DMA_PAGE, pick_page());
		while (bus.dma_on) begin
			if ($urandom_range(0, 7) == 0) begin
				r = make_req($urandom_range(0, 1) ? ccbus_pkg::OP_WRITE : ccbus_pkg::OP_READ,
					pick_addr(), 8'($urandom_range(0, 255)));
				if (r.operation == ccbus_pkg::OP_WRITE && r.address == ccbus_pkg::ADDR_DMA_PAGE)
					r.operation = ccbus_pkg::OP_READ;
				send(r);
			end else begin
				send_op(ccbus_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			bus.check_response(rsp);
	end

	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_gap();
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		#(64'd20_000_000);
		$display("console_cpu_bus_with_oam_dma_top_tb: errors");
		$finish;
	end

	initial begin
		int phase_start;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		sent = 0;
		calm = 1'b0;
		bus = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_mixed(sent + 40);
		wait_drained();
		run_full_dma();
		wait_drained();
		phase_start = sent;
		run_mixed(phase_start + 30);
		wait_drained();
		repeat (10) @(posedge clk);
		$display("beats sent %0d, responses checked %0d, mismatches %0d",
			sent, bus.checked, bus.mismatches);
		$display("sprite bytes stored %0d, whole transfers %0d, pad bit reads %0d",
			bus.oam_bytes, bus.dma_done, bus.pad_reads);
		if (bus.mismatches == 0 && bus.pending() == 0) begin
			$display("console_cpu_bus_with_oam_dma_top_tb: clean");
		end else begin
			$display("console_cpu_bus_with_oam_dma_top_tb: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/ccbus_pkg.sv
rtl/core/console_cpu_bus_with_oam_dma_top.sv
sim/console_cpu_bus_with_oam_dma_top_tb.sv
